// File: hw/rtl/rhd_pkg.sv
// ----------------------------------------------------------------------------
// rhd_pkg
// Types, register indexes and pixel arithmetic for the RGBA half-size
// downsampler.
// ----------------------------------------------------------------------------
package rhd_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT = 4'd1;

   // frame height limit and row counter width
   localparam int MAX_HEIGHT = 4096;
   localparam int ROW_W      = 12;
   localparam int RESET_SIZE = 64;

   // one input pixel
   typedef struct packed {
      logic [7:0] alpha_in;
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_payload_type;

   // one output pixel
   typedef struct packed {
      logic       frame_end;
      logic [7:0] alpha_out;
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
   } rsp_payload_type;

   // horizontal pair sums, as kept in the line store
   typedef struct packed {
      logic [8:0] alpha;
      logic [8:0] blue;
      logic [8:0] green;
      logic [8:0] red;
   } pair_sum_type;

   // channel-wise sum of two neighbouring pixels
   function automatic pair_sum_type pair_sum(input req_payload_type a,
                                             input req_payload_type b);
      pair_sum_type r;
      r.red   = {1'b0, a.red_in}   + {1'b0, b.red_in};
      r.green = {1'b0, a.green_in} + {1'b0, b.green_in};
      r.blue  = {1'b0, a.blue_in}  + {1'b0, b.blue_in};
      r.alpha = {1'b0, a.alpha_in} + {1'b0, b.alpha_in};
      return r;
   endfunction

   // two pair sums into one truncated 2x2 average
   function automatic logic [7:0] box_avg(input logic [8:0] a, input logic [8:0] b);
      logic [9:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[9:2];
   endfunction

endpackage

// File: hw/rtl/rhd_line_store.sv
// ----------------------------------------------------------------------------
// rhd_line_store
// Line store with separate write and read ports for the pair sums of an even row;
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module rhd_line_store
   import rhd_pkg::*;
#(
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  pair_sum_type             wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output pair_sum_type             rd_data
);

   pair_sum_type mem [DEPTH];
   pair_sum_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rgba_half_downsampler_core.sv
// ----------------------------------------------------------------------------
// rgba_half_downsampler_core
// 2x2 box-filter downsampler for a raster-order RGBA8 pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one output pixel for each 2x2 block, in
// raster order of the half-size image; frame_end marks the last one. On
// acceptance an item's horizontal pair sum is formed and either written to the
// line store (even rows) or the stored pair is read (odd rows); the second
// stage then adds the read data and loads the output register. The line store
// sees at most one access per item, so the rate stays at one item per clock
// while rsp_ready is high. Frames with a width or height of 2 or less pass
// every pixel through. A write to the width or height register restarts the
// frame. The line store needs no clearing after reset.
module rgba_half_downsampler_core
   import rhd_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data
);

   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int COLW  = $clog2(MAX_WIDTH);
   localparam int CMPW  = (CW > CSR_DATA_W) ? CW : CSR_DATA_W;
   localparam int HW    = CSR_DATA_W;
   localparam logic [CW-1:0] RESET_W =
      CW'((MAX_WIDTH < RESET_SIZE) ? MAX_WIDTH : RESET_SIZE);

   // effective frame size
   logic [CW-1:0]   eff_w_ff, eff_w_in;
   logic [HW-1:0]   eff_h_ff, eff_h_in;
   logic            restart;
   logic [CMPW-1:0] wdata_x;

   always_comb begin
      wdata_x  = CMPW'(csr_wdata);
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      restart  = 1'b0;
      if (csr_we) begin
         case (csr_addr)
            REG_FRAME_WIDTH: begin
               restart = 1'b1;
               if (csr_wdata == '0) begin
                  eff_w_in = CW'(1);
               end else if (wdata_x > CMPW'(MAX_WIDTH)) begin
                  eff_w_in = CW'(MAX_WIDTH);
               end else begin
                  eff_w_in = wdata_x[CW-1:0];
               end
            end
            REG_FRAME_HEIGHT: begin
               restart = 1'b1;
               if (csr_wdata == '0) begin
                  eff_h_in = HW'(1);
               end else if (csr_wdata > HW'(MAX_HEIGHT)) begin
                  eff_h_in = HW'(MAX_HEIGHT);
               end else begin
                  eff_h_in = csr_wdata;
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff <= RESET_W;
         eff_h_ff <= HW'(RESET_SIZE);
      end else begin
         eff_w_ff <= eff_w_in;
         eff_h_ff <= eff_h_in;
      end
   end

   // derived frame geometry
   logic [CW-1:0] w_even;
   logic [HW-1:0] h_even;
   logic          pass_mode;

   assign w_even    = {eff_w_ff[CW-1:1], 1'b0};
   assign h_even    = {eff_h_ff[HW-1:1], 1'b0};
   assign pass_mode = (eff_w_ff <= CW'(2)) || (eff_h_ff <= HW'(2));

   // handshake between input, second stage and output register
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, s1_move, accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   // position in the frame
   logic [COLW-1:0]  col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    col_x;
   logic [HW-1:0]    row_x;
   logic             last_col, last_row, in_region, odd_col, odd_row;

   assign col_x     = CW'(col_ff);
   assign row_x     = HW'(row_ff);
   assign last_col  = col_x >= (eff_w_ff - CW'(1));
   assign last_row  = row_x >= (eff_h_ff - HW'(1));
   assign in_region = (col_x < w_even) && (row_x < h_even);
   assign odd_col   = col_ff[0];
   assign odd_row   = row_ff[0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COLW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // left pixel of the current pair
   req_payload_type held_ff;
   pair_sum_type    ps;
   logic            take_left, pair_wr, pair_rd;

   assign take_left = accept && !pass_mode && in_region && !odd_col;
   assign pair_wr   = accept && !pass_mode && in_region && odd_col && !odd_row;
   assign pair_rd   = accept && !pass_mode && in_region && odd_col && odd_row;
   assign ps        = pair_sum(held_ff, req_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (take_left) begin
         held_ff <= req_data;
      end
   end

   // line store of even-row pair sums
   pair_sum_type up_sum;

   rhd_line_store #(
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (pair_wr),
      .wr_addr (col_ff[AW:1]),
      .wr_data (ps),
      .rd_en   (pair_rd),
      .rd_addr (col_ff[AW:1]),
      .rd_data (up_sum)
   );

   // second stage: pair sum waiting for the stored row, or a passed pixel
   pair_sum_type    s1_sum_ff;
   req_payload_type s1_pix_ff;
   logic            s1_comb_ff;
   logic            s1_end_ff;
   logic            s1_load;

   assign s1_load = accept && (pass_mode || pair_rd);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sum_ff  <= ps;
         s1_pix_ff  <= req_data;
         s1_comb_ff <= !pass_mode;
         if (pass_mode) begin
            s1_end_ff <= last_col && last_row;
         end else begin
            s1_end_ff <= ((row_x + HW'(1)) == h_even) && ((col_x + CW'(1)) == w_even);
         end
      end
   end

   // output register
   rsp_payload_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in.frame_end = s1_end_ff;
      if (s1_comb_ff) begin
         rsp_data_in.red_out   = box_avg(up_sum.red,   s1_sum_ff.red);
         rsp_data_in.green_out = box_avg(up_sum.green, s1_sum_ff.green);
         rsp_data_in.blue_out  = box_avg(up_sum.blue,  s1_sum_ff.blue);
         rsp_data_in.alpha_out = box_avg(up_sum.alpha, s1_sum_ff.alpha);
      end else begin
         rsp_data_in.red_out   = s1_pix_ff.red_in;
         rsp_data_in.green_out = s1_pix_ff.green_in;
         rsp_data_in.blue_out  = s1_pix_ff.blue_in;
         rsp_data_in.alpha_out = s1_pix_ff.alpha_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: verif/rhd_downsample_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rhd_downsample_checker
// Watches the configuration port and both pixel channels of the downsampler,
// keeps its own copy of frame size, position and line store, works out each
// output pixel as input items are taken and compares every output item, field
// by field, with the oldest pixel still owed.
// ----------------------------------------------------------------------------
module rhd_downsample_checker
   import rhd_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_data,
   output int                    mismatch_count,
   output int                    pending_pixels
);

   localparam int LINE_DEPTH  = MAX_WIDTH / 2;
   localparam int PRINT_LIMIT = 40;

   // frame size as written, position of the next input pixel
   logic [CSR_DATA_W-1:0] frame_width;
   logic [CSR_DATA_W-1:0] frame_height;
   int unsigned           col_pos;
   int unsigned           row_pos;

   // horizontal pair sums of the last even row, red in the lowest lane
   logic [3:0][8:0]       line_sums [LINE_DEPTH];
   req_payload_type       held_left;

   // output pixels still owed, oldest first
   rsp_payload_type       expected_pixels [$];
   int                    outputs_seen;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch at output %0d: %s", $time, outputs_seen, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string field, input int unsigned got,
                                input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, wanted %0d", field, got, want));
   endtask

   // zero reads as one, anything above the limit as the limit
   function automatic int unsigned clamp_size(input logic [CSR_DATA_W-1:0] v,
                                              input int unsigned limit);
      if (v == '0)
         return 1;
      if (v > limit)
         return limit;
      return v;
   endfunction

   // one input pixel in, at most one output pixel out; moves the position on
   function automatic bit predict_output_pixel(input req_payload_type px,
                                               output rsp_payload_type res);
      int unsigned     w, h, hw, hh, idx;
      bit              last_col, last_row, produced;
      logic [3:0][8:0] pair;
      logic [9:0]      block;
      w        = clamp_size(frame_width, MAX_WIDTH);
      h        = clamp_size(frame_height, MAX_HEIGHT);
      hw       = w / 2;
      hh       = h / 2;
      last_col = col_pos >= w - 1;
      last_row = row_pos >= h - 1;
      produced = 1'b0;
      res      = '0;
      if (w <= 2 || h <= 2) begin
         // tiny frames pass every pixel straight through
         res.red_out   = px.red_in;
         res.green_out = px.green_in;
         res.blue_out  = px.blue_in;
         res.alpha_out = px.alpha_in;
         res.frame_end = last_col && last_row;
         produced      = 1'b1;
      end else if (col_pos < 2 * hw && row_pos < 2 * hh) begin
         if (col_pos % 2 == 0) begin
            held_left = px;
         end else begin
            idx = col_pos / 2;
            for (int c = 0; c < 4; c++)
               pair[c] = {1'b0, held_left[8*c +: 8]} + {1'b0, px[8*c +: 8]};
            if (row_pos % 2 == 0) begin
               line_sums[idx] = pair;
            end else begin
               for (int c = 0; c < 4; c++) begin
                  block           = {1'b0, line_sums[idx][c]} + {1'b0, pair[c]};
                  res[8*c +: 8]   = block[9:2];
               end
               res.frame_end = (row_pos == 2 * hh - 1) && (col_pos == 2 * hw - 1);
               produced      = 1'b1;
            end
         end
      end
      // raster position, wrapping at the end of the frame
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return produced;
   endfunction

   task automatic check_output_pixel(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("output item %h arrived with nothing owed", got));
      end else begin
         want = expected_pixels.pop_front();
         compare_field("red_out",   got.red_out,   want.red_out);
         compare_field("green_out", got.green_out, want.green_out);
         compare_field("blue_out",  got.blue_out,  want.blue_out);
         compare_field("alpha_out", got.alpha_out, want.alpha_out);
         compare_field("frame_end", got.frame_end, want.frame_end);
      end
      outputs_seen++;
   endtask

   // everything sampled on the rising edge, outputs checked before new input
   always @(posedge clock) begin
      rsp_payload_type next_pixel;
      if (reset) begin
         frame_width    = CSR_DATA_W'(RESET_SIZE);
         frame_height   = CSR_DATA_W'(RESET_SIZE);
         col_pos        = 0;
         row_pos        = 0;
         held_left      = '0;
         mismatch_count = 0;
         outputs_seen   = 0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_output_pixel(rsp_data);
         if (csr_we) begin
            case (csr_addr)
               REG_FRAME_WIDTH: begin
                  frame_width = csr_wdata;
                  col_pos     = 0;
                  row_pos     = 0;
               end
               REG_FRAME_HEIGHT: begin
                  frame_height = csr_wdata;
                  col_pos      = 0;
                  row_pos      = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (predict_output_pixel(req_data, next_pixel))
               expected_pixels.push_back(next_pixel);
         end
      end
      pending_pixels = expected_pixels.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the RGBA half-size downsampler: a handful of hand-made frames
// with full-scale, zero and truncating blocks, then random pixels over many
// frame sizes (odd, tiny, zero, clamped and the full line width), with bursty
// input, changing output back-pressure and restarts by register writes.
// ----------------------------------------------------------------------------
module tb;
   import rhd_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SIZED_ITEMS    = 200;
   localparam logic [CSR_DATA_W-1:0] FULL_WIDTH = CSR_DATA_W'(4096);
   localparam logic [CSR_DATA_W-1:0] FIELD_MAX  = CSR_DATA_W'(8191);

   // an index with no register behind it
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 4'hE;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_data;

   int                    mismatch_count;
   int                    pending_pixels;

   // sender burst state
   int unsigned           burst_left = 0;
   bit                    sender_steady = 1'b0;

   // receiver pattern state
   rx_mode_type           rx_mode = RX_OPEN;
   int unsigned           rx_cycle = 0;
   int unsigned           rx_hold = 0;
   bit                    rx_level = 1'b1;

   int unsigned           idle_cycles = 0;

   // 4x4 frame: full-scale and zero blocks on top, truncating blocks below
   logic [31:0] directed_4x4 [16] = '{
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
      32'h00FFFF01, 32'h80402010, 32'hFF00FF00, 32'h01010101,
      32'hFF00FFFF, 32'h7F7F7F7F, 32'h00FF00FF, 32'h01010100
   };

   rgba_half_downsampler_core dut (
      .clock,
      .reset,
      .csr_we,
      .csr_addr,
      .csr_wdata,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data
   );

   rhd_downsample_checker pixel_check (
      .clock,
      .reset,
      .csr_we,
      .csr_addr,
      .csr_wdata,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .mismatch_count,
      .pending_pixels
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // receiver: back-pressure pattern picked afresh at random: open, random, periodic or bursty
   always @(negedge clock) begin
      if (rx_cycle % 64 == 0)
         rx_mode = rx_mode_type'($urandom_range(0, 3));
      rx_cycle++;
      case (rx_mode)
         RX_OPEN:     rsp_ready <= 1'b1;
         RX_RANDOM:   rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_PERIODIC: rsp_ready <= (rx_cycle % 5 >= 2);
         default: begin
            if (rx_hold == 0) begin
               rx_level = ~rx_level;
               rx_hold  = $urandom_range(1, 12);
            end else begin
               rx_hold--;
            end
            rsp_ready <= rx_level;
         end
      endcase
   end

   // watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_frame(input logic [CSR_DATA_W-1:0] w,
                            input logic [CSR_DATA_W-1:0] h);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
   endtask

   // one item on the input channel, with a random gap between bursts
   task automatic send_pixel(input req_payload_type px);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = sender_steady ? 0 : $urandom_range(0, 12);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= px;
      burst_left--;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_pixels(input int unsigned n);
      repeat (n) send_pixel($urandom());
   endtask

   // hold input, let every owed pixel out and the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_pixels == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_frames(input logic [CSR_DATA_W-1:0] w,
                             input logic [CSR_DATA_W-1:0] h, input int unsigned n);
      settle();
      set_frame(w, h);
      sender_steady = ($urandom_range(0, 3) == 0);
      send_random_pixels(n);
   endtask

   initial begin
      int unsigned fw, fh, n, sized_items;
      clock     = 1'b0;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_addr  = REG_FRAME_WIDTH;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // hand-made 4x4 frame
      set_frame(4, 4);
      foreach (directed_4x4[i])
         send_pixel(directed_4x4[i]);
      settle();

      // zero height read as one row; two wide passes pixels through
      set_frame(2, 0);
      send_pixel('1);
      send_pixel('0);

      // odd sizes drop the last column and row
      run_frames(3, 3, 27);
      run_frames(5, 7, 70);
      // zero width read as one column
      run_frames(0, 9, 18);
      run_frames(7, 2, 28);
      // heights at and above the limit, then a clamped width
      run_frames(4, FIELD_MAX, 64);
      run_frames(2, FULL_WIDTH, 24);
      run_frames(FIELD_MAX, 1, 40);
      // widest frame, start of the top row only
      run_frames(FULL_WIDTH, 3, 30);
      // clamped width, downsampling, cut short by the next restart
      run_frames(FIELD_MAX, 5, 40);

      // unused index mid-frame must not restart the frame
      run_frames(6, 4, 12);
      settle();
      write_reg(REG_UNUSED, CSR_DATA_W'($urandom()));
      send_random_pixels(60);

      // pause mid-frame until every owed pixel is out
      run_frames(10, 6, 25);
      settle();
      send_random_pixels(95);

      // random sizes: mostly whole frames, some broken off by a restart
      sized_items = 0;
      while (sized_items < SIZED_ITEMS) begin
         fw = $urandom_range(1, 18);
         fh = $urandom_range(1, 10);
         if ($urandom_range(0, 4) == 0)
            n = $urandom_range(1, fw * fh);
         else
            n = fw * fh * $urandom_range(1, 2);
         run_frames(CSR_DATA_W'(fw), CSR_DATA_W'(fh), n);
         sized_items += n;
      end

      settle();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/rhd_pkg.sv
hw/rtl/rhd_line_store.sv
hw/rtl/rgba_half_downsampler_core.sv
verif/rhd_downsample_checker.sv
verif/tb.sv
